// File: hw/rtl/clt_pkg.sv
// ----------------------------------------------------------------------------
// clt_pkg: shared types and constants of the command line tokenizer
// Holds the result item type, the per-byte result bundle and the character
// helpers that the tokenizer datapath and its result buffer use.
// ----------------------------------------------------------------------------
package clt_pkg;

   localparam int unsigned RES_MAX   = 3;
   localparam int unsigned CNT_WIDTH = 2;

   localparam logic [7:0] CH_NUL    = 8'h00;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_DASH   = 8'h2D;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_LOW_N  = 8'h6E;
   localparam logic [7:0] CH_LOW_R  = 8'h72;
   localparam logic [7:0] CH_LOW_T  = 8'h74;

   typedef struct packed {
      logic [7:0] out_char;
      logic       has_char;
      logic       command_name;
      logic       token_end;
      logic       line_end;
   } result_type;

   typedef struct packed {
      logic [CNT_WIDTH-1:0]     count;
      result_type [RES_MAX-1:0] slot;
   } bundle_type;

   function automatic logic is_ws(input logic [7:0] c);
      is_ws = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) || (c == CH_CR);
   endfunction

   function automatic logic [7:0] decode_escape(input logic [7:0] c);
      logic [7:0] d;
      d = c;
      if (c == CH_LOW_N) d = CH_LF;
      else if (c == CH_LOW_R) d = CH_CR;
      else if (c == CH_LOW_T) d = CH_TAB;
      decode_escape = d;
   endfunction

endpackage

// File: hw/rtl/clt_step.sv
// ----------------------------------------------------------------------------
// clt_step: tokenizer state and per-byte decode
// Holds the scanner state and turns one registered byte into a bundle of up
// to three result items; the state advances when the bundle is taken.
// ----------------------------------------------------------------------------
module clt_step (
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  logic [7:0]          in_byte,
   input  logic                end_of_line,
   output clt_pkg::bundle_type bundle
);

   localparam logic [1:0] MODE_BETWEEN     = 2'd0;
   localparam logic [1:0] MODE_WORD        = 2'd1;
   localparam logic [1:0] MODE_QUOTED      = 2'd2;
   localparam logic [1:0] MODE_AFTER_QUOTE = 2'd3;
   localparam int unsigned NCAND = 5;

   logic [1:0] mode_ff, mode_in;
   logic       esc_ff, esc_in;
   logic       seen_ff, seen_in;
   logic [7:0] held_ff, held_in;
   logic [1:0] tlen_ff, tlen_in;
   logic       tcmd_ff, tcmd_in;

   logic       is_line;
   logic       do_add;
   logic       do_close;
   logic [7:0] add_c;
   logic [1:0] cnt;
   clt_pkg::result_type cand [NCAND];
   logic [NCAND-1:0]    cen;

   always_comb begin
      mode_in  = mode_ff;
      esc_in   = esc_ff;
      seen_in  = seen_ff;
      held_in  = held_ff;
      tlen_in  = tlen_ff;
      tcmd_in  = tcmd_ff;
      do_add   = 1'b0;
      do_close = 1'b0;
      add_c    = in_byte;
      cen      = '0;
      for (int i = 0; i < NCAND; i++) begin
         cand[i] = '0;
      end
      is_line = (in_byte == clt_pkg::CH_NUL) || end_of_line;

      if (in_byte != clt_pkg::CH_NUL) begin
         unique case (mode_ff) inside
            MODE_WORD, MODE_QUOTED: begin
               if (esc_ff) begin
                  esc_in = 1'b0;
                  do_add = 1'b1;
                  add_c  = clt_pkg::decode_escape(in_byte);
               end else if (in_byte == clt_pkg::CH_BSLASH) begin
                  esc_in = 1'b1;
               end else if (mode_ff == MODE_WORD && clt_pkg::is_ws(in_byte)) begin
                  do_close = 1'b1;
                  mode_in  = MODE_BETWEEN;
               end else if (mode_ff == MODE_QUOTED && in_byte == clt_pkg::CH_QUOTE) begin
                  do_close = 1'b1;
                  mode_in  = MODE_AFTER_QUOTE;
               end else begin
                  do_add = 1'b1;
               end
            end
            MODE_AFTER_QUOTE: begin
               mode_in = MODE_BETWEEN;
            end
            default: begin
               esc_in  = 1'b0;
               held_in = '0;
               tlen_in = '0;
               tcmd_in = 1'b0;
               if (clt_pkg::is_ws(in_byte)) begin
                  mode_in = MODE_BETWEEN;
               end else if (in_byte == clt_pkg::CH_QUOTE) begin
                  mode_in = MODE_QUOTED;
               end else if (in_byte == clt_pkg::CH_BSLASH) begin
                  mode_in = MODE_WORD;
                  esc_in  = 1'b1;
               end else begin
                  mode_in = MODE_WORD;
                  do_add  = 1'b1;
               end
            end
         endcase
      end

      // An escape left open at the end of the line stands for a backslash.
      if (is_line) begin
         if (esc_in) begin
            do_add = 1'b1;
            add_c  = clt_pkg::CH_BSLASH;
         end
         esc_in   = 1'b0;
         do_close = 1'b1;
      end

      // Append one decoded character; a leading dash is held back.
      if (do_add) begin
         if (tlen_in == 2'd0) begin
            held_in = add_c;
            tlen_in = 2'd1;
            if (add_c != clt_pkg::CH_DASH && seen_in) begin
               cen[0]  = 1'b1;
               cand[0] = '{out_char: add_c, has_char: 1'b1, command_name: 1'b0,
                           token_end: 1'b0, line_end: 1'b0};
            end
         end else if (tlen_in == 2'd1 && held_in == clt_pkg::CH_DASH) begin
            tlen_in = 2'd2;
            if (!clt_pkg::is_ws(add_c)) begin
               tcmd_in = 1'b1;
               seen_in = 1'b1;
               cen[0]  = 1'b1;
               cand[0] = '{out_char: add_c, has_char: 1'b1, command_name: 1'b1,
                           token_end: 1'b0, line_end: 1'b0};
            end else if (seen_in) begin
               cen[0]  = 1'b1;
               cand[0] = '{out_char: clt_pkg::CH_DASH, has_char: 1'b1,
                           command_name: 1'b0, token_end: 1'b0, line_end: 1'b0};
               cen[1]  = 1'b1;
               cand[1] = '{out_char: add_c, has_char: 1'b1, command_name: 1'b0,
                           token_end: 1'b0, line_end: 1'b0};
            end
         end else begin
            tlen_in = 2'd2;
            if (tcmd_in || seen_in) begin
               cen[0]  = 1'b1;
               cand[0] = '{out_char: add_c, has_char: 1'b1, command_name: tcmd_in,
                           token_end: 1'b0, line_end: 1'b0};
            end
         end
      end

      // Close the open token; a lone dash becomes an ordinary argument.
      if (do_close) begin
         if (tlen_in == 2'd1 && held_in == clt_pkg::CH_DASH && seen_in) begin
            cen[2]  = 1'b1;
            cand[2] = '{out_char: clt_pkg::CH_DASH, has_char: 1'b1,
                        command_name: 1'b0, token_end: 1'b0, line_end: 1'b0};
         end
         if (tcmd_in || (seen_in && tlen_in != 2'd0)) begin
            cen[3]  = 1'b1;
            cand[3] = '{out_char: clt_pkg::CH_NUL, has_char: 1'b0,
                        command_name: tcmd_in, token_end: 1'b1, line_end: 1'b0};
         end
         held_in = '0;
         tlen_in = '0;
         tcmd_in = 1'b0;
      end

      if (is_line) begin
         mode_in = MODE_BETWEEN;
         seen_in = 1'b0;
         cen[4]  = (cen[3:0] == 4'b0000);
      end

      // Pack the enabled candidates in order into the bundle.
      cnt          = '0;
      bundle.slot  = '0;
      for (int i = 0; i < NCAND; i++) begin
         if (cen[i] && cnt != 2'd3) begin
            bundle.slot[cnt] = cand[i];
            cnt              = cnt + 2'd1;
         end
      end
      if (is_line) begin
         case (cnt)
            2'd1:    bundle.slot[0].line_end = 1'b1;
            2'd2:    bundle.slot[1].line_end = 1'b1;
            2'd3:    bundle.slot[2].line_end = 1'b1;
            default: bundle.slot[0].line_end = 1'b0;
         endcase
      end
      bundle.count = cnt;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_BETWEEN;
         esc_ff  <= 1'b0;
         seen_ff <= 1'b0;
         held_ff <= '0;
         tlen_ff <= '0;
         tcmd_ff <= 1'b0;
      end else if (advance) begin
         mode_ff <= mode_in;
         esc_ff  <= esc_in;
         seen_ff <= seen_in;
         held_ff <= held_in;
         tlen_ff <= tlen_in;
         tcmd_ff <= tcmd_in;
      end
   end

   // Every line leaves the scanner exactly as reset does.
   a_line_resets_state: assert property (@(posedge clock) disable iff (reset)
      (advance && is_line) |=> (mode_ff == MODE_BETWEEN && !esc_ff && !seen_ff &&
                                tlen_ff == 2'd0 && !tcmd_ff))
      else $error("scanner state not cleared after end of line");

   // A line always closes with exactly one marked result, the last one.
   a_line_end_on_last: assert property (@(posedge clock) disable iff (reset)
      (advance && is_line) |->
                  ((bundle.count == 2'd1 && bundle.slot[0].line_end) ||
                   (bundle.count == 2'd2 && bundle.slot[1].line_end &&
                    !bundle.slot[0].line_end) ||
                   (bundle.count == 2'd3 && bundle.slot[2].line_end &&
                    !bundle.slot[1].line_end && !bundle.slot[0].line_end)))
      else $error("line end not on the last result of the line");

endmodule

// File: hw/rtl/clt_result_buf.sv
// ----------------------------------------------------------------------------
// clt_result_buf: result bundle register
// Holds the results of one byte and hands them out one transfer at a time,
// taking the next bundle as the last held result leaves.
// ----------------------------------------------------------------------------
module clt_result_buf (
   input  logic                clock,
   input  logic                reset,
   input  logic                load,
   input  clt_pkg::bundle_type bundle,
   output logic                can_load,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output clt_pkg::result_type head
);

   clt_pkg::result_type [clt_pkg::RES_MAX-1:0] slot_ff;
   logic [clt_pkg::CNT_WIDTH-1:0]              cnt_ff;
   logic                                       xfer;

   assign rsp_valid = (cnt_ff != '0);
   assign xfer      = rsp_valid && !rsp_stall;
   assign can_load  = (cnt_ff == '0) || (cnt_ff == 2'd1 && xfer);
   assign head      = slot_ff[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (load) begin
         cnt_ff <= bundle.count;
      end else if (xfer) begin
         cnt_ff <= cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         slot_ff <= bundle.slot;
      end else if (xfer) begin
         slot_ff[0] <= slot_ff[1];
         slot_ff[1] <= slot_ff[2];
      end
   end

   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      load |-> can_load)
      else $error("bundle loaded over undelivered results");

endmodule

// File: hw/rtl/command_line_tokenizer_unit.sv
// ----------------------------------------------------------------------------
// command_line_tokenizer_unit: streaming command line tokenizer
// Splits a line into whitespace or quoted tokens, decodes backslash escapes
// and emits command name and argument characters with token and line ends.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Ports                               Transfer
//   req      in         req_in_byte, req_end_of_line        req_valid & !req_stall
//   rsp      out        rsp_out_char, rsp_has_char,         rsp_valid & !rsp_stall
//                       rsp_command_name, rsp_token_end,
//                       rsp_line_end
//
// A transfer loads the input register; the byte is decoded combinationally and
// its up to three results load into the result register once it can take them;
// the first is then offered at rsp. A byte is taken every cycle while rsp is not
// stalled and each byte yields at most one result; a byte with k results holds
// the result register for k transfers. Reset is synchronous and clears the
// scanner. rsp_stall reaches req_stall at once.
//
module command_line_tokenizer_unit (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_in_byte,
   input  logic       req_end_of_line,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_char,
   output logic       rsp_has_char,
   output logic       rsp_command_name,
   output logic       rsp_token_end,
   output logic       rsp_line_end
);

   // Input register: one byte waiting for the decoder.
   logic       in_valid_ff, in_valid_in;
   logic [7:0] byte_ff;
   logic       eol_ff;

   logic                can_load;
   logic                advance;
   clt_pkg::bundle_type bundle;
   clt_pkg::result_type head;

   // The held byte moves on whenever the result register can take its bundle.
   assign advance   = in_valid_ff && can_load;
   assign req_stall = in_valid_ff && !can_load;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_valid && !req_stall) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         byte_ff <= req_in_byte;
         eol_ff  <= req_end_of_line;
      end
   end

   // Scanner state and per-byte decode.
   clt_step u_step (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .in_byte     (byte_ff),
      .end_of_line (eol_ff),
      .bundle      (bundle)
   );

   // Result register, drained one transfer at a time.
   clt_result_buf u_result_buf (
      .clock     (clock),
      .reset     (reset),
      .load      (advance),
      .bundle    (bundle),
      .can_load  (can_load),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .head      (head)
   );

   assign rsp_out_char     = head.out_char;
   assign rsp_has_char     = head.has_char;
   assign rsp_command_name = head.command_name;
   assign rsp_token_end    = head.token_end;
   assign rsp_line_end     = head.line_end;

   // A byte that cannot move on stays in the input register untouched.
   a_held_byte_kept: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=> (in_valid_ff && $stable(byte_ff) && $stable(eol_ff)))
      else $error("held input byte lost or changed");

endmodule
